// ===== hdl/fep_pkg.sv =====
// Package for the fire spread block: field widths, operation codes, controller
// command and status structs and the heat palette lookup.
// No dependencies.
package fep_pkg;

   localparam int WIDTH_DEF  = 320;
   localparam int HEIGHT_DEF = 56;

   localparam int OP_W     = 2;
   localparam int ORIGIN_W = 15;
   localparam int RAND_W   = 2;
   localparam int DEST_W   = 15;
   localparam int COLOUR_W = 16;
   localparam int HEAT_W   = 6;

   localparam logic [OP_W-1:0] OP_UPDATE     = 2'd0;
   localparam logic [OP_W-1:0] OP_IGNITE     = 2'd1;
   localparam logic [OP_W-1:0] OP_EXTINGUISH = 2'd2;

   localparam logic [HEAT_W-1:0]   IGNITE_HEAT   = 6'd34;
   localparam logic [COLOUR_W-1:0] COLOUR_CLEAR  = 16'd0;
   localparam logic [COLOUR_W-1:0] COLOUR_WHITE  = 16'd65535;

   typedef struct packed {
      logic capture;    // word accepted: latch fields, read source heat
      logic sweep;      // write one entry of a sweep, advance counter
      logic clear_sel;  // sweep covers the whole store with zero
      logic update;     // write destination, load result register
   } cmd_type;

   typedef struct packed {
      logic row_last;   // sweep counter at last column
      logic all_last;   // sweep counter at last entry
      logic rsp_busy;   // result register full and not taken this cycle
   } status_type;

   function automatic logic [COLOUR_W-1:0] heat_colour(input logic [HEAT_W-1:0] heat);
      logic [COLOUR_W-1:0] c;
      case (heat)
         6'd0:  c = COLOUR_CLEAR;
         6'd1:  c = 16'd32771;
         6'd2:  c = 16'd32085;
         6'd3:  c = 16'd32808;
         6'd4:  c = 16'd32842;
         6'd5:  c = 16'd32876;
         6'd6:  c = 16'd32878;
         6'd7:  c = 16'd32913;
         6'd8:  c = 16'd32947;
         6'd9:  c = 16'd33013;
         6'd10: c = 16'd33047;
         6'd11: c = 16'd33048;
         6'd12: c = 16'd33083;
         6'd13: c = 16'd33115;
         6'd14: c = 16'd33115;
         6'd15: c = 16'd33146;
         6'd16: c = 16'd34202;
         6'd17: c = 16'd34233;
         6'd18: c = 16'd34265;
         6'd19: c = 16'd34297;
         6'd20: c = 16'd35353;
         6'd21: c = 16'd35352;
         6'd22: c = 16'd35352;
         6'd23: c = 16'd36440;
         6'd24: c = 16'd36471;
         6'd25: c = 16'd36471;
         6'd26: c = 16'd37527;
         6'd27: c = 16'd37527;
         6'd28: c = 16'd38583;
         6'd29: c = 16'd38582;
         6'd30: c = 16'd38614;
         6'd31: c = 16'd39638;
         6'd32: c = 16'd46905;
         6'd33: c = 16'd53115;
         6'd34: c = 16'd58301;
         default: c = COLOUR_WHITE;
      endcase
      return c;
   endfunction

endpackage

// ===== hdl/fep_if.sv =====
// Channel interfaces of the fire spread block: request and response words
// with valid/ready handshake. Depends on fep_pkg.
interface fep_req_if;
   logic                           valid;
   logic                           ready;
   logic [fep_pkg::OP_W-1:0]       operation;
   logic [fep_pkg::ORIGIN_W-1:0]   origin;
   logic [fep_pkg::RAND_W-1:0]     random_shift;

   modport source (output valid, operation, origin, random_shift, input ready);
   modport sink   (input valid, operation, origin, random_shift, output ready);
endinterface

interface fep_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [fep_pkg::DEST_W-1:0]     dest_address;
   logic [fep_pkg::COLOUR_W-1:0]   pixel_colour;

   modport source (output valid, dest_address, pixel_colour, input ready);
   modport sink   (input valid, dest_address, pixel_colour, output ready);
endinterface

// ===== hdl/fep_ctrl.sv =====
// Controller of the fire spread block: clearing pass, word acceptance,
// update and row fill sequencing. Depends on fep_pkg.
module fep_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic [fep_pkg::OP_W-1:0]   req_operation,
   output logic                       req_ready,
   input  fep_pkg::status_type        status,
   output fep_pkg::cmd_type           cmd
);
   import fep_pkg::*;

   typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_UPDATE, ST_FILL} state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (status.all_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               case (req_operation)
                  OP_UPDATE: state_in = ST_UPDATE;
                  OP_IGNITE, OP_EXTINGUISH: state_in = ST_FILL;
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_UPDATE: begin
            if (!status.rsp_busy) state_in = ST_IDLE;
         end
         ST_FILL: begin
            if (status.row_last) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready     = (state_ff == ST_IDLE);
   assign cmd.capture   = (state_ff == ST_IDLE) && req_valid;
   assign cmd.sweep     = (state_ff == ST_CLEAR) || (state_ff == ST_FILL);
   assign cmd.clear_sel = (state_ff == ST_CLEAR);
   assign cmd.update    = (state_ff == ST_UPDATE) && !status.rsp_busy;

endmodule

// ===== hdl/fep_datapath.sv =====
// Datapath of the fire spread block: heat store, address arithmetic, decay,
// palette lookup, sweep counter and result register. Depends on fep_pkg.
module fep_datapath #(
   parameter int WIDTH  = fep_pkg::WIDTH_DEF,
   parameter int HEIGHT = fep_pkg::HEIGHT_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [fep_pkg::OP_W-1:0]      req_operation,
   input  logic [fep_pkg::ORIGIN_W-1:0]  req_origin,
   input  logic [fep_pkg::RAND_W-1:0]    req_random_shift,
   input  fep_pkg::cmd_type              cmd,
   output fep_pkg::status_type           status,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [fep_pkg::DEST_W-1:0]    rsp_dest_address,
   output logic [fep_pkg::COLOUR_W-1:0]  rsp_pixel_colour
);
   import fep_pkg::*;

   localparam int CELLS  = WIDTH * HEIGHT;
   localparam int ADDR_W = $clog2(CELLS);
   localparam int EXT_W  = (ADDR_W > ORIGIN_W) ? ADDR_W : ORIGIN_W;
   localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);
   localparam logic [ADDR_W-1:0] LAST_COL  = ADDR_W'(WIDTH - 1);
   localparam logic [ADDR_W-1:0] ROW_BASE  = ADDR_W'((HEIGHT - 1) * WIDTH);
   localparam logic [ADDR_W:0]   WIDTH_EXT = (ADDR_W + 1)'(WIDTH);

   logic [HEAT_W-1:0] heat_mem [CELLS];

   logic [ADDR_W-1:0]   src_ff, src_in;
   logic [RAND_W-1:0]   rand_ff;
   logic [HEAT_W-1:0]   fill_heat_ff;
   logic [HEAT_W-1:0]   rd_heat_ff;
   logic [ADDR_W-1:0]   count_ff, count_in;
   logic                rsp_valid_ff;
   logic [DEST_W-1:0]   dest_ff;
   logic [COLOUR_W-1:0] colour_ff;

   logic [EXT_W-1:0]    origin_ext;
   logic [ADDR_W:0]     src_plus;
   logic [ADDR_W:0]     drift;
   logic [ADDR_W-1:0]   dest;
   logic [EXT_W-1:0]    dest_ext;
   logic [HEAT_W-1:0]   new_heat;
   logic                sweep_last;
   logic                wr_en;
   logic [ADDR_W-1:0]   wr_addr;
   logic [HEAT_W-1:0]   wr_data;

   // origin saturates at the last entry
   assign origin_ext = EXT_W'(req_origin);
   assign src_in     = (origin_ext >= EXT_W'(CELLS)) ? LAST_CELL : origin_ext[ADDR_W-1:0];

   // one row up, drifted by one minus the random value, clamped at zero
   assign src_plus = {1'b0, src_ff} + (ADDR_W + 1)'(1);
   assign drift    = WIDTH_EXT + (ADDR_W + 1)'(rand_ff);
   always_comb begin
      dest = '0;
      if (src_plus >= drift) begin
         dest = ADDR_W'(src_plus - drift);
      end
   end
   assign dest_ext = EXT_W'(dest);

   assign new_heat = (rand_ff[0] && (rd_heat_ff != '0)) ? rd_heat_ff - HEAT_W'(1) : rd_heat_ff;

   assign sweep_last = cmd.clear_sel ? (count_ff == LAST_CELL) : (count_ff == LAST_COL);
   assign count_in   = sweep_last ? '0 : count_ff + ADDR_W'(1);

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = count_ff;
      wr_data = '0;
      if (cmd.update) begin
         wr_en   = 1'b1;
         wr_addr = dest;
         wr_data = new_heat;
      end else if (cmd.sweep) begin
         wr_en   = 1'b1;
         wr_addr = cmd.clear_sel ? count_ff : ROW_BASE + count_ff;
         wr_data = cmd.clear_sel ? '0 : fill_heat_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         heat_mem[wr_addr] <= wr_data;
      end
      if (cmd.capture) begin
         rd_heat_ff <= heat_mem[src_in];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         src_ff       <= src_in;
         rand_ff      <= req_random_shift;
         fill_heat_ff <= (req_operation == OP_IGNITE) ? IGNITE_HEAT : '0;
      end
      if (cmd.update) begin
         dest_ff   <= dest_ext[DEST_W-1:0];
         colour_ff <= heat_colour(new_heat);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.sweep) count_ff <= count_in;
         if (cmd.update) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign status.row_last = (count_ff == LAST_COL);
   assign status.all_last = (count_ff == LAST_CELL);
   assign status.rsp_busy = rsp_valid_ff && !rsp_ready;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_dest_address = dest_ff;
   assign rsp_pixel_colour = colour_ff;

endmodule

// ===== hdl/fire_effect_pixel_spread_top.sv =====
// Top level of the fire spread block: joins controller and datapath to the
// request and response channels. Depends on fep_pkg, fep_if, fep_ctrl, fep_datapath.
//
// Request words carry an operation, an origin pixel and a 2-bit random value.
// Update spreads the origin's heat to the pixel one row up, drifted sideways,
// and returns one response word: destination address and its palette colour.
// Ignite and extinguish rewrite the bottom row and return nothing; an unused
// operation code is accepted and dropped.
// Update: the word is taken, the source heat is read from the store into a
// register, and the update state then writes the destination and loads the
// response register. A new word is taken only once that write is done, as
// reads and writes share the single-port heat store.
// Ignite and extinguish make one store write per column of the bottom row.
// After reset a clearing pass zeroes the store, one entry a cycle, over all
// WIDTH*HEIGHT entries (17920 at the defaults) with req ready held low.
// A stalled response holds in its register; further words are still taken,
// and a following update waits in its write cycle until the register frees.
module fire_effect_pixel_spread_top #(
   parameter int WIDTH  = fep_pkg::WIDTH_DEF,
   parameter int HEIGHT = fep_pkg::HEIGHT_DEF
) (
   input  logic      clock,
   input  logic      reset,
   fep_req_if.sink   req_ch,
   fep_rsp_if.source rsp_ch
);
   import fep_pkg::*;

   cmd_type    cmd;
   status_type status;

   fep_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_ch.valid),
      .req_operation (req_ch.operation),
      .req_ready     (req_ch.ready),
      .status        (status),
      .cmd           (cmd)
   );

   fep_datapath #(
      .WIDTH  (WIDTH),
      .HEIGHT (HEIGHT)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_operation    (req_ch.operation),
      .req_origin       (req_ch.origin),
      .req_random_shift (req_ch.random_shift),
      .cmd              (cmd),
      .status           (status),
      .rsp_valid        (rsp_ch.valid),
      .rsp_ready        (rsp_ch.ready),
      .rsp_dest_address (rsp_ch.dest_address),
      .rsp_pixel_colour (rsp_ch.pixel_colour)
   );

endmodule

// ===== dv/tb.sv =====
// Testbench for fire_effect_pixel_spread_top: drives request words, keeps its own heat map
// and palette, and checks every response word against the predicted pixel.
// Depends on fep_pkg, fep_if and the RTL of the block.
`timescale 1ns / 1ps

module tb;
   import fep_pkg::*;

   localparam int COLS        = WIDTH_DEF;
   localparam int ROWS        = HEIGHT_DEF;
   localparam int CELLS       = COLS * ROWS;
   localparam int PALETTE_TOP = 35;
   localparam int STALL_LIMIT = 60000;

   localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

   localparam logic [COLOUR_W-1:0] FLAME_COLOURS [0:PALETTE_TOP] = '{
      16'd0,
      16'd32771, 16'd32085, 16'd32808, 16'd32842, 16'd32876, 16'd32878, 16'd32913, 16'd32947,
      16'd33013, 16'd33047, 16'd33048, 16'd33083, 16'd33115, 16'd33115, 16'd33146, 16'd34202,
      16'd34233, 16'd34265, 16'd34297, 16'd35353, 16'd35352, 16'd35352, 16'd36440, 16'd36471,
      16'd36471, 16'd37527, 16'd37527, 16'd38583, 16'd38582, 16'd38614, 16'd39638,
      16'd46905, 16'd53115, 16'd58301,
      16'd65535
   };

   typedef struct packed {
      logic [DEST_W-1:0]   dest;
      logic [COLOUR_W-1:0] colour;
   } pixel_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   fep_req_if req_ch();
   fep_rsp_if rsp_ch();

   fire_effect_pixel_spread_top uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   logic [HEAT_W-1:0] heat_map [CELLS];
   pixel_word_type    pending_pixels [$];
   pixel_word_type    due_pixel;
   int                fault_count = 0;
   int                hold_left   = 0;
   int                quiet_cycles = 0;
   bit                steady      = 1'b0;

   always #2 clock = ~clock;

   // gap length: mostly none or short, now and then long
   function automatic int pick_pause();
      int unsigned v;
      v = $urandom_range(0, 99);
      if (v < 60)
         return 0;
      else if (v < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic void predict_word(input logic [OP_W-1:0] op,
                                        input logic [ORIGIN_W-1:0] org,
                                        input logic [RAND_W-1:0] rs);
      int                src;
      int                dst;
      int                col;
      logic [HEAT_W-1:0] heat;
      pixel_word_type    w;
      case (op)
         OP_IGNITE: begin
            for (col = 0; col < COLS; col++)
               heat_map[(ROWS - 1) * COLS + col] = IGNITE_HEAT;
         end
         OP_EXTINGUISH: begin
            for (col = 0; col < COLS; col++)
               heat_map[(ROWS - 1) * COLS + col] = '0;
         end
         OP_UPDATE: begin
            src = (int'(org) >= CELLS) ? CELLS - 1 : int'(org);
            dst = src - COLS - int'(rs) + 1;
            if (dst < 0)
               dst = 0;
            heat = heat_map[src];
            if (rs[0] && heat != '0)
               heat = heat - HEAT_W'(1);
            heat_map[dst] = heat;
            w.dest   = DEST_W'(dst);
            w.colour = (heat > PALETTE_TOP) ? FLAME_COLOURS[PALETTE_TOP] : FLAME_COLOURS[heat];
            pending_pixels.push_back(w);
         end
         default: ;
      endcase
   endfunction

   // valid is left high after acceptance so back-to-back words need no extra edge
   task automatic send_word(input logic [OP_W-1:0] op, input logic [ORIGIN_W-1:0] org,
                            input logic [RAND_W-1:0] rs);
      int pause;
      pause = steady ? 0 : pick_pause();
      if (pause > 0) begin
         req_ch.valid <= 1'b0;
         repeat (pause) @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.operation    <= op;
      req_ch.origin       <= org;
      req_ch.random_shift <= rs;
      do @(posedge clock); while (!req_ch.ready);
      predict_word(op, org, rs);
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (pending_pixels.size() != 0)
         @(posedge clock);
   endtask

   task automatic random_word();
      int unsigned         v;
      logic [OP_W-1:0]     op;
      logic [ORIGIN_W-1:0] org;
      v = $urandom_range(0, 99);
      if (v < 70)
         op = OP_UPDATE;
      else if (v < 80)
         op = OP_IGNITE;
      else if (v < 90)
         op = OP_EXTINGUISH;
      else
         op = OP_SPARE;
      v = $urandom_range(0, 3);
      if (v < 2)
         org = ORIGIN_W'($urandom_range(0, CELLS - 1));
      else if (v == 2)
         org = ORIGIN_W'($urandom_range((ROWS - 2) * COLS, CELLS - 1));
      else
         org = ORIGIN_W'($urandom);
      send_word(op, org, RAND_W'($urandom));
   endtask

   task automatic test_edge_cases();
      send_word(OP_UPDATE, ORIGIN_W'(0), RAND_W'(0));
      send_word(OP_UPDATE, ORIGIN_W'(0), RAND_W'(3));
      send_word(OP_SPARE, '1, '1);
      send_word(OP_IGNITE, '0, '0);
      send_word(OP_UPDATE, ORIGIN_W'(CELLS - 1), RAND_W'(0));
      send_word(OP_UPDATE, ORIGIN_W'(CELLS - 1), RAND_W'(1));
      send_word(OP_UPDATE, ORIGIN_W'(CELLS), RAND_W'(2));
      send_word(OP_UPDATE, '1, RAND_W'(3));
      send_word(OP_UPDATE, ORIGIN_W'((ROWS - 1) * COLS), RAND_W'(1));
      send_word(OP_UPDATE, ORIGIN_W'((ROWS - 2) * COLS), RAND_W'(0));
      send_word(OP_UPDATE, ORIGIN_W'(2 * COLS), RAND_W'(3));
      send_word(OP_UPDATE, ORIGIN_W'(COLS), RAND_W'(3));
      send_word(OP_UPDATE, ORIGIN_W'(COLS - 1), RAND_W'(2));
      send_word(OP_EXTINGUISH, '1, '1);
      send_word(OP_UPDATE, ORIGIN_W'(CELLS - 1), RAND_W'(1));
      send_word(OP_UPDATE, ORIGIN_W'((ROWS - 1) * COLS), RAND_W'(1));
      send_word(OP_UPDATE, ORIGIN_W'((ROWS - 2) * COLS), RAND_W'(3));
   endtask

   // one frame over a column window, bottom row upwards, with stray words mixed in
   task automatic run_fire_frame(input int first_col, input int span, input bit douse);
      int row;
      int col;
      send_word(OP_IGNITE, ORIGIN_W'($urandom), RAND_W'($urandom));
      for (row = ROWS - 1; row >= 0; row--) begin
         if (douse && row == ROWS / 2)
            send_word(OP_EXTINGUISH, ORIGIN_W'($urandom), RAND_W'($urandom));
         for (col = first_col; col < first_col + span; col++) begin
            if ($urandom_range(0, 19) == 0)
               random_word();
            send_word(OP_UPDATE, ORIGIN_W'(row * COLS + col), RAND_W'($urandom_range(0, 3)));
         end
      end
   endtask

   task automatic test_fire_frames();
      run_fire_frame(0, 6, 1'b0);
      steady = 1'b1;
      run_fire_frame($urandom_range(0, COLS - 6), 6, 1'b0);
      steady = 1'b0;
      run_fire_frame($urandom_range(0, COLS - 6), 6, 1'b1);
      run_fire_frame(COLS - 6, 6, 1'b0);
   endtask

   task automatic test_drain_pause();
      int n;
      send_word(OP_IGNITE, '0, '0);
      for (n = 0; n < 20; n++)
         send_word(OP_UPDATE, ORIGIN_W'($urandom_range((ROWS - 2) * COLS, CELLS - 1)),
                   RAND_W'($urandom));
      wait_drained();
      for (n = 0; n < 10; n++)
         send_word(OP_UPDATE, ORIGIN_W'($urandom_range((ROWS - 3) * COLS, CELLS - 1)),
                   RAND_W'($urandom));
   endtask

   task automatic test_noise();
      int n;
      for (n = 0; n < 500; n++)
         random_word();
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (steady) begin
         rsp_ch.ready <= 1'b1;
      end else if (hold_left > 0) begin
         rsp_ch.ready <= 1'b0;
         hold_left    <= hold_left - 1;
      end else begin
         rsp_ch.ready <= 1'b1;
         if ($urandom_range(0, 99) < 25)
            hold_left <= pick_pause();
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_pixels.size() == 0) begin
            $display("%0t: unexpected word dest %0d colour %0d", $time,
                     rsp_ch.dest_address, rsp_ch.pixel_colour);
            fault_count++;
         end else begin
            due_pixel = pending_pixels.pop_front();
            if (rsp_ch.dest_address !== due_pixel.dest) begin
               $display("%0t: dest_address expected %0d actual %0d", $time,
                        due_pixel.dest, rsp_ch.dest_address);
               fault_count++;
            end
            if (rsp_ch.pixel_colour !== due_pixel.colour) begin
               $display("%0t: pixel_colour expected %0d actual %0d", $time,
                        due_pixel.colour, rsp_ch.pixel_colour);
               fault_count++;
            end
         end
      end
   end

   // watchdog; allows for the clearing pass after reset
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      req_ch.valid        <= 1'b0;
      req_ch.operation    <= OP_UPDATE;
      req_ch.origin       <= '0;
      req_ch.random_shift <= '0;
      for (int i = 0; i < CELLS; i++)
         heat_map[i] = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_edge_cases();
      test_fire_frames();
      test_drain_pause();
      test_noise();
      wait_drained();
      repeat (COLS + 8) @(posedge clock);
      if (fault_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
